// ===== rtl/yy420w_pkg.sv =====
// ============================================================================
// yy420w_pkg
// Shared constants for the YUYV 4:2:2 to planar YUV 4:2:0 writer.
// ============================================================================
`default_nettype none

package yy420w_pkg;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Field widths
    localparam int CFG_W    = 13;   // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W   = 26;
    localparam int PIX_W    = 8;

    // Stream widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 112;  // 110 bits of fields, zero filled to bytes
    localparam int M_USER_W = 1;

    // Output tdata bit offsets
    localparam int M_LUMA_ADDR_LSB = 0;
    localparam int M_Y0_LSB        = 26;
    localparam int M_Y1_LSB        = 34;
    localparam int M_BLUE_ADDR_LSB = 42;
    localparam int M_BLUE_LSB      = 68;
    localparam int M_RED_ADDR_LSB  = 76;
    localparam int M_RED_LSB       = 102;
    localparam int M_USED_W        = 110;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_BY_SIDE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_OFFSET  = 2'd3;

    // Reset configuration and the plane starts that follow from it
    localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0]  RST_SIDE_OFFSET  = 13'd0;
    localparam logic [ADDR_W-1:0] RST_AREA         = 26'd307200;
    localparam logic [ADDR_W-1:0] RST_LUMA_PTR     = 26'd0;
    localparam logic [ADDR_W-1:0] RST_BLUE_PTR     = 26'd307200;
    localparam logic [ADDR_W-1:0] RST_RED_PTR      = 26'd384000;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [PIX_W-1:0]  pix_t;

endpackage

`default_nettype wire

// ===== rtl/yuyv_to_yuv420_planar_writer_top.sv =====
// ============================================================================
// yuyv_to_yuv420_planar_writer_top
// Converts packed YUYV pairs to planar YUV 4:2:0 write beats.
// ============================================================================
// Each input beat carries one YUYV group (two pixels); each output beat gives
// the two luma bytes with their byte offset in the luma plane and, on even
// rows, the U and V bytes with their offsets in the U and V planes (odd rows
// give chroma_write = 0 and zero chroma fields). One beat is accepted per
// clock unless the output stalls; every input beat makes exactly one output
// beat, via the input and result registers. The plane starts come from a
// registered width*height product that follows the configuration in the next
// cycle. tuser on input marks start of frame; tlast on output marks the last
// pair of the frame, after which the counters restart on their own.
// Side-by-side mode lays the image into a double-width frame at side_offset.
// ============================================================================
`default_nettype none

module yuyv_to_yuv420_planar_writer_top
    import yy420w_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // tdata: luma_first, chroma_blue, luma_second, chroma_red
    input  wire logic [S_DATA_W-1:0]  s_axis_tdata,
    // tuser: start_of_frame
    input  wire logic [S_USER_W-1:0]  s_axis_tuser,
    // output stream
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: luma_addr, luma_out_first, luma_out_second, blue_addr,
    //        blue_out, red_addr, red_out, zero fill
    output      logic [M_DATA_W-1:0]  m_axis_tdata,
    // tuser: chroma_write
    output      logic [M_USER_W-1:0]  m_axis_tuser,
    // tlast: frame_done
    output      logic                 m_axis_tlast
);

    localparam int PC_W  = $clog2(MAX_WIDTH / 2);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [CFG_W:0] MAX_W_C = (CFG_W + 1)'(MAX_WIDTH);
    localparam logic [CFG_W:0] MAX_H_C = (CFG_W + 1)'(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic             side_by_side_reg;
    logic [CFG_W-1:0] side_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            side_by_side_reg <= 1'b0;
            side_offset_reg  <= RST_SIDE_OFFSET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_SIDE_BY_SIDE: side_by_side_reg <= cfg_data[0];
                REG_SIDE_OFFSET:  side_offset_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective geometry: clamp to the limits, height at least one row,
    // at least one pair per row
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic [CFG_W-1:0]   w_even;
    logic [CFG_W-2:0]   pairs_raw;
    logic [CFG_W-2:0]   pairs;

    always_comb
    begin
        w_eff = ({1'b0, image_width_reg} > MAX_W_C) ? CFG_W'(MAX_WIDTH) : image_width_reg;
        h_eff = ({1'b0, image_height_reg} > MAX_H_C) ? CFG_W'(MAX_HEIGHT) : image_height_reg;
        if (h_eff == '0)
            h_eff = CFG_W'(1);
        w_even    = {w_eff[CFG_W-1:1], 1'b0};
        pairs_raw = w_eff[CFG_W-1:1];
        pairs     = (pairs_raw == '0) ? (CFG_W - 1)'(1) : pairs_raw;
    end

    // Frame area, registered after the multiplier
    addr_t area_reg;
    addr_t area_next;

    assign area_next = ADDR_W'(w_even) * ADDR_W'(h_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            area_reg <= RST_AREA;
        else
            area_reg <= area_next;
    end

    // Plane starts at a restart
    addr_t rs_luma;
    addr_t rs_blue;
    addr_t rs_red;
    addr_t half_off;

    always_comb
    begin
        half_off = ADDR_W'(side_offset_reg[CFG_W-1:1]);
        if (side_by_side_reg)
        begin
            rs_luma = ADDR_W'(side_offset_reg);
            rs_blue = (area_reg << 1) + half_off;
            rs_red  = (area_reg << 1) + (area_reg >> 1) + half_off;
        end
        else
        begin
            rs_luma = '0;
            rs_blue = area_reg;
            rs_red  = area_reg + (area_reg >> 2);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register, then result register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign fire          = s1_valid_reg && advance;

    logic s1_sof_reg;
    pix_t s1_y0_reg;
    pix_t s1_u_reg;
    pix_t s1_y1_reg;
    pix_t s1_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_sof_reg <= s_axis_tuser[0];
            s1_y0_reg  <= s_axis_tdata[7:0];
            s1_u_reg   <= s_axis_tdata[15:8];
            s1_y1_reg  <= s_axis_tdata[23:16];
            s1_v_reg   <= s_axis_tdata[31:24];
        end
    end

    // ------------------------------------------------------------------
    // Counters and plane pointers
    // ------------------------------------------------------------------
    logic [PC_W-1:0]  pair_column_reg, pair_column_next;
    logic [ROW_W-1:0] row_index_reg, row_index_next;
    addr_t            luma_ptr_reg, luma_ptr_next;
    addr_t            blue_ptr_reg, blue_ptr_next;
    addr_t            red_ptr_reg, red_ptr_next;

    logic [PC_W-1:0]  pc_cur;
    logic [ROW_W-1:0] row_cur;
    addr_t            luma_cur;
    addr_t            blue_cur;
    addr_t            red_cur;
    logic             even;
    logic             end_row;
    logic             last;

    always_comb
    begin
        // start of frame restarts before this pair
        pc_cur   = s1_sof_reg ? '0 : pair_column_reg;
        row_cur  = s1_sof_reg ? '0 : row_index_reg;
        luma_cur = s1_sof_reg ? rs_luma : luma_ptr_reg;
        blue_cur = s1_sof_reg ? rs_blue : blue_ptr_reg;
        red_cur  = s1_sof_reg ? rs_red  : red_ptr_reg;

        even    = !row_cur[0];
        end_row = (CFG_W'(pc_cur) + CFG_W'(1)) >= {1'b0, pairs};
        last    = 1'b0;

        luma_ptr_next    = luma_cur + ADDR_W'(2);
        blue_ptr_next    = even ? blue_cur + ADDR_W'(1) : blue_cur;
        red_ptr_next     = even ? red_cur + ADDR_W'(1) : red_cur;
        pair_column_next = pc_cur + PC_W'(1);
        row_index_next   = row_cur;

        if (end_row)
        begin
            pair_column_next = '0;
            if (side_by_side_reg)
            begin
                luma_ptr_next = luma_ptr_next + ADDR_W'(w_eff);
                if (!even)
                begin
                    // odd row ends: chroma skips the other half of the wide row
                    blue_ptr_next = blue_ptr_next + ADDR_W'(w_eff[CFG_W-1:1]);
                    red_ptr_next  = red_ptr_next + ADDR_W'(w_eff[CFG_W-1:1]);
                end
            end
            if ((CFG_W'(row_cur) + CFG_W'(1)) >= h_eff)
            begin
                // end of frame: restart on our own
                last             = 1'b1;
                row_index_next   = '0;
                luma_ptr_next    = rs_luma;
                blue_ptr_next    = rs_blue;
                red_ptr_next     = rs_red;
            end
            else
            begin
                row_index_next = row_cur + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_column_reg <= '0;
            row_index_reg   <= '0;
            luma_ptr_reg    <= RST_LUMA_PTR;
            blue_ptr_reg    <= RST_BLUE_PTR;
            red_ptr_reg     <= RST_RED_PTR;
        end
        else if (fire)
        begin
            pair_column_reg <= pair_column_next;
            row_index_reg   <= row_index_next;
            luma_ptr_reg    <= luma_ptr_next;
            blue_ptr_reg    <= blue_ptr_next;
            red_ptr_reg     <= red_ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    addr_t out_luma_addr_reg;
    pix_t  out_y0_reg;
    pix_t  out_y1_reg;
    logic  out_chroma_reg;
    addr_t out_blue_addr_reg;
    pix_t  out_blue_reg;
    addr_t out_red_addr_reg;
    pix_t  out_red_reg;
    logic  out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_luma_addr_reg <= luma_cur;
            out_y0_reg        <= s1_y0_reg;
            out_y1_reg        <= s1_y1_reg;
            out_chroma_reg    <= even;
            out_blue_addr_reg <= even ? blue_cur : '0;
            out_blue_reg      <= even ? s1_u_reg : '0;
            out_red_addr_reg  <= even ? red_cur : '0;
            out_red_reg       <= even ? s1_v_reg : '0;
            out_last_reg      <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_DATA_W - M_USED_W)'(0), out_red_reg, out_red_addr_reg,
                            out_blue_reg, out_blue_addr_reg, out_y1_reg, out_y0_reg,
                            out_luma_addr_reg};
    assign m_axis_tuser  = out_chroma_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/yy420w_checker.sv =====
// ============================================================================
// yy420w_checker
// Port-level assertions for the YUYV to planar 4:2:0 writer.
// ============================================================================
`default_nettype none

module yy420w_checker
    import yy420w_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic [M_USER_W-1:0] m_axis_tuser,
    input wire logic                m_axis_tlast
);

    // beats accepted but not yet delivered
    logic [2:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 3'(in_beat) - 3'(out_beat);
    end

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // no output beat without an accepted input beat
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("output beat with no pending input");

    // at most two beats in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more beats in flight than stages");

    // odd rows carry zero chroma fields
    a_odd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[M_USED_W-1:M_BLUE_ADDR_LSB] == '0)
        else $error("chroma fields not zero on odd row");

    // input is taken on an empty pipeline
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> s_axis_tready)
        else $error("input stalled on empty pipeline");

endmodule

bind yuyv_to_yuv420_planar_writer_top yy420w_checker u_yy420w_checker (.*);

`default_nettype wire
